/* rtl/sha1_block_compression_macros.svh */
// ----------------------------------------------------------------------------
// SHA-1 block compression assertion macros
// Clocked assertion helpers shared by the SHA-1 compression RTL.
// ----------------------------------------------------------------------------
`ifndef SHA1_BLOCK_COMPRESSION_MACROS_SVH
`define SHA1_BLOCK_COMPRESSION_MACROS_SVH

// check an implication on every clock edge outside reset
`define SHA1BC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define SHA1BC_NEVER(lbl, cond, msg) \
   `SHA1BC_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/sha1bc_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 block compression package
// Word type, control structs and fixed SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1bc_pkg;

   typedef logic [31:0] word_type;

   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_WORDS  = 16;
   localparam int TOTAL_ROUNDS = 80;

   localparam word_type INIT_CHAIN [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type GROUP_CONST [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [1:0] GRP_CHOOSE  = 2'd0;
   localparam logic [1:0] GRP_PARITY1 = 2'd1;
   localparam logic [1:0] GRP_MAJOR   = 2'd2;
   localparam logic [1:0] GRP_PARITY2 = 2'd3;

   // schedule window control
   typedef struct packed {
      logic load;   // shift in a message word
      logic step;   // shift in the next expanded word
   } sched_ctl_type;

   // round unit control
   typedef struct packed {
      logic       init;   // copy chaining words into working words
      logic       step;   // run one round
      logic [1:0] group;  // round group selects function and constant
   } round_ctl_type;

endpackage

/* rtl/sha1bc_sched.sv */
// ----------------------------------------------------------------------------
// SHA-1 message schedule window
// Sixteen-word shift line; the oldest tap feeds the round, the recurrence
// taps produce the next expanded word.
// ----------------------------------------------------------------------------
module sha1bc_sched (
   input  logic                      clock,
   input  sha1bc_pkg::sched_ctl_type ctl,
   input  sha1bc_pkg::word_type      message_word,
   output sha1bc_pkg::word_type      round_word
);

   sha1bc_pkg::word_type win_ff [sha1bc_pkg::BLOCK_WORDS];
   sha1bc_pkg::word_type win_in [sha1bc_pkg::BLOCK_WORDS];
   sha1bc_pkg::word_type mix;
   sha1bc_pkg::word_type expand;

   assign mix        = win_ff[2] ^ win_ff[7] ^ win_ff[13] ^ win_ff[15];
   assign expand     = {mix[30:0], mix[31]};
   assign round_word = win_ff[15];

   always_comb begin
      for (int k = 0; k < sha1bc_pkg::BLOCK_WORDS; k++) begin
         win_in[k] = win_ff[k];
      end
      if (ctl.load || ctl.step) begin
         for (int k = 1; k < sha1bc_pkg::BLOCK_WORDS; k++) begin
            win_in[k] = win_ff[k-1];
         end
         win_in[0] = ctl.load ? message_word : expand;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

/* rtl/sha1bc_round.sv */
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Five working words and the shared round adder, one round per cycle.
// ----------------------------------------------------------------------------
module sha1bc_round (
   input  logic                      clock,
   input  sha1bc_pkg::round_ctl_type ctl,
   input  sha1bc_pkg::word_type      chain_words   [sha1bc_pkg::DIGEST_WORDS],
   input  sha1bc_pkg::word_type      round_word,
   output sha1bc_pkg::word_type      working_words [sha1bc_pkg::DIGEST_WORDS]
);

   sha1bc_pkg::word_type work_ff [sha1bc_pkg::DIGEST_WORDS];
   sha1bc_pkg::word_type work_in [sha1bc_pkg::DIGEST_WORDS];
   sha1bc_pkg::word_type mix;
   sha1bc_pkg::word_type tmp;
   sha1bc_pkg::word_type a_rot;
   sha1bc_pkg::word_type b_rot;

   always_comb begin
      case (ctl.group)
         sha1bc_pkg::GRP_CHOOSE:
            mix = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         sha1bc_pkg::GRP_MAJOR:
            mix = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                | (work_ff[2] & work_ff[3]);
         default:
            mix = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign a_rot = {work_ff[0][26:0], work_ff[0][31:27]};
   assign b_rot = {work_ff[1][1:0], work_ff[1][31:2]};
   assign tmp   = a_rot + mix + work_ff[4] + round_word + sha1bc_pkg::GROUP_CONST[ctl.group];

   always_comb begin
      work_in = work_ff;
      if (ctl.init) begin
         work_in = chain_words;
      end else if (ctl.step) begin
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = b_rot;
         work_in[1] = work_ff[0];
         work_in[0] = tmp;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign working_words = work_ff;

endmodule

/* rtl/sha1_block_compression.sv */
// ----------------------------------------------------------------------------
// SHA-1 block compression
// Word-serial SHA-1 compression with chaining and digest readout.
// ----------------------------------------------------------------------------
// Feed padded blocks as sixteen big-endian words on the req_ channel. Set
// req_start_message on the first word of a message to reload the initial
// chaining values; a start word in mid-block drops the partial block.
// On the sixteenth word the block drops req_ready and runs 80 rounds, one
// per cycle in the shared round adder, then folds the working words into
// the chaining words in its add state before it takes the next block.
// If req_final_block was set on the sixteenth word, the five digest words
// follow on the rsp_ channel, index 0 first, digest_last on index 4; each
// word holds until rsp_ready takes it, and req_ready stays low until the
// last one is taken. The chaining words then return to the initial values.
// Synchronous reset loads the initial chaining values and clears the word
// count, round count and sequencer; the block is ready the cycle after.
// ----------------------------------------------------------------------------
`include "sha1_block_compression_macros.svh"

module sha1_block_compression (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic        req_start_message,
   input  logic        req_final_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   localparam logic [1:0] S_LOAD  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_ADD   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   localparam logic [6:0] LAST_ROUND = 7'(sha1bc_pkg::TOTAL_ROUNDS - 1);
   localparam logic [3:0] LAST_WORD  = 4'(sha1bc_pkg::BLOCK_WORDS - 1);
   localparam logic [2:0] LAST_INDEX = 3'(sha1bc_pkg::DIGEST_WORDS - 1);

   logic [1:0] state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] index_ff, index_in;
   logic       final_ff, final_in;
   sha1bc_pkg::word_type chain_ff [sha1bc_pkg::DIGEST_WORDS];
   sha1bc_pkg::word_type chain_in [sha1bc_pkg::DIGEST_WORDS];
   sha1bc_pkg::word_type work     [sha1bc_pkg::DIGEST_WORDS];
   sha1bc_pkg::word_type round_word;

   sha1bc_pkg::sched_ctl_type sched_ctl;
   sha1bc_pkg::round_ctl_type round_ctl;

   logic       req_take;
   logic       rsp_take;
   logic [3:0] pos;

   assign req_ready = (state_ff == S_LOAD);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign pos       = req_start_message ? 4'd0 : count_ff;

   assign rsp_digest_word  = chain_ff[index_ff];
   assign rsp_digest_index = index_ff;
   assign rsp_digest_last  = (index_ff == LAST_INDEX);

   always_comb begin
      sched_ctl.load  = req_take;
      sched_ctl.step  = (state_ff == S_ROUND);
      round_ctl.init  = req_take && (pos == LAST_WORD);
      round_ctl.step  = (state_ff == S_ROUND);
      if (round_ff < 7'd20) begin
         round_ctl.group = sha1bc_pkg::GRP_CHOOSE;
      end else if (round_ff < 7'd40) begin
         round_ctl.group = sha1bc_pkg::GRP_PARITY1;
      end else if (round_ff < 7'd60) begin
         round_ctl.group = sha1bc_pkg::GRP_MAJOR;
      end else begin
         round_ctl.group = sha1bc_pkg::GRP_PARITY2;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      index_in = index_ff;
      final_in = final_ff;
      chain_in = chain_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               if (req_start_message) begin
                  chain_in = sha1bc_pkg::INIT_CHAIN;
               end
               if (pos == LAST_WORD) begin
                  count_in = 4'd0;
                  round_in = 7'd0;
                  final_in = req_final_block;
                  state_in = S_ROUND;
               end else begin
                  count_in = pos + 4'd1;
               end
            end
         end
         S_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               round_in = 7'd0;
               state_in = S_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         S_ADD: begin
            for (int k = 0; k < sha1bc_pkg::DIGEST_WORDS; k++) begin
               chain_in[k] = chain_ff[k] + work[k];
            end
            index_in = 3'd0;
            state_in = final_ff ? S_EMIT : S_LOAD;
         end
         S_EMIT: begin
            if (rsp_take) begin
               if (index_ff == LAST_INDEX) begin
                  chain_in = sha1bc_pkg::INIT_CHAIN;
                  index_in = 3'd0;
                  state_in = S_LOAD;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= 4'd0;
         round_ff <= 7'd0;
         index_ff <= 3'd0;
         final_ff <= 1'b0;
         chain_ff <= sha1bc_pkg::INIT_CHAIN;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         index_ff <= index_in;
         final_ff <= final_in;
         chain_ff <= chain_in;
      end
   end

   sha1bc_sched u_sched (
      .clock        (clock),
      .ctl          (sched_ctl),
      .message_word (req_message_word),
      .round_word   (round_word)
   );

   sha1bc_round u_round (
      .clock         (clock),
      .ctl           (round_ctl),
      .chain_words   (chain_ff),
      .round_word    (round_word),
      .working_words (work)
   );

   `SHA1BC_NEVER(a_no_overlap, req_ready && rsp_valid, "input and digest channels both active")
   `SHA1BC_ASSERT(a_round_range, (state_ff != S_ROUND) || (round_ff <= LAST_ROUND), "round count out of range")
   `SHA1BC_ASSERT(a_round_done, (state_ff == S_ROUND && round_ff == LAST_ROUND) |=> (state_ff == S_ADD), "compression did not end after last round")
   `SHA1BC_ASSERT(a_chain_restore, (rsp_take && rsp_digest_last) |=> (chain_ff[0] == sha1bc_pkg::INIT_CHAIN[0] && state_ff == S_LOAD), "chaining words not restored after digest")
   `SHA1BC_ASSERT(a_index_range, (state_ff != S_EMIT) || (index_ff <= LAST_INDEX), "digest index out of range")

endmodule
